### rtl/core/vgwa_pkg.sv
// ---------------------------------------------------------------------------
// Voxel grid weight accumulator package
// Shared constants, codes and types for the front end, the request queue
// and the cell store of the voxel grid weight accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package vgwa_pkg;

    // Grid geometry.
    localparam int DIVS       = 32;
    localparam int HALF       = DIVS / 2;
    localparam int AXIS_BITS  = $clog2(DIVS);
    localparam int CELL_COUNT = DIVS * DIVS * DIVS;
    localparam int CELL_BITS  = $clog2(CELL_COUNT);

    // Field widths.
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 15;
    localparam int CFG_IDX_W = 3;

    // Request kinds.
    typedef enum logic {
        REQ_ACCUM = 1'b0,
        REQ_READ  = 1'b1
    } req_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE = 3'd5;

    // Register file contents as seen by the front end.
    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic signed [COORD_W-1:0] centre_z;
        logic signed [COORD_W-1:0] extent_min;
        logic signed [COORD_W-1:0] extent_max;
        logic        [COORD_W-1:0] cell_scale;
    } cfg_t;

    // One classified request travelling from the front end to the back end.
    typedef struct packed {
        req_t                 req_type;
        logic                 in_grid;
        logic [CELL_BITS-1:0] cell_idx;
        logic [WEIGHT_W-1:0]  weight;
    } q_entry_t;

endpackage : vgwa_pkg

`default_nettype wire

### rtl/core/vgwa_front.sv
// ---------------------------------------------------------------------------
// Voxel grid front end
// Accepts a request beat, tests it against the cube and maps each axis of an
// inside point to a cell with one shared offset, multiply and clamp datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module vgwa_front
    import vgwa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                hold,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire req_t                in_req,
    input  wire logic [COORD_W-1:0]  in_px,
    input  wire logic [COORD_W-1:0]  in_py,
    input  wire logic [COORD_W-1:0]  in_pz,
    input  wire logic [WEIGHT_W-1:0] in_weight,
    output logic                     push,
    output q_entry_t                 push_entry,
    input  wire logic                full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_OFF,
        F_MUL,
        F_POS,
        F_PUSH
    } fstate_t;

    fstate_t                 state_reg;
    req_t                    req_reg;
    logic [WEIGHT_W-1:0]     weight_reg;
    logic [COORD_W-1:0]      pt_reg [3];
    logic                    inside_reg;
    logic [1:0]              axis_reg;
    logic                    neg_reg;
    logic [COORD_W-1:0]      mag_reg;
    logic [2*COORD_W-1:0]    prod_reg;
    logic [CELL_BITS-1:0]    idx_reg;

    logic                    in_box;
    logic signed [COORD_W-1:0] centre_sel;
    logic [COORD_W:0]        off;
    logic [COORD_W:0]        off_neg;
    logic                    neg_next;
    logic [COORD_W-1:0]      mag_next;
    logic [COORD_W-1:0]      hi;
    logic [COORD_W:0]        ceil_v;
    logic [AXIS_BITS-1:0]    pos;
    logic [CELL_BITS-1:0]    idx_next;

    assign in_ready = (state_reg == F_IDLE) && !hold;

    // Cube test on the raw coordinates of the incoming beat.
    assign in_box = ($signed(in_px) >= cfg.extent_min) && ($signed(in_px) <= cfg.extent_max)
                 && ($signed(in_py) >= cfg.extent_min) && ($signed(in_py) <= cfg.extent_max)
                 && ($signed(in_pz) >= cfg.extent_min) && ($signed(in_pz) <= cfg.extent_max);

    // Offset from the centre for the axis in progress, as sign and magnitude.
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    centre_sel = cfg.centre_x;
            2'd1:    centre_sel = cfg.centre_y;
            default: centre_sel = cfg.centre_z;
        endcase
        off      = {pt_reg[axis_reg][COORD_W-1], pt_reg[axis_reg]}
                 - {centre_sel[COORD_W-1], centre_sel};
        off_neg  = ~off + {{COORD_W{1'b0}}, 1'b1};
        neg_next = off[COORD_W];
        mag_next = neg_next ? off_neg[COORD_W-1:0] : off[COORD_W-1:0];
    end

    // Floor of the scaled offset plus half the grid, clamped to the grid.
    always_comb
    begin
        hi     = prod_reg[2*COORD_W-1:COORD_W];
        ceil_v = {1'b0, hi} + {{COORD_W{1'b0}}, |prod_reg[COORD_W-1:0]};
        if (neg_reg)
        begin
            if (ceil_v >= (COORD_W+1)'(HALF))
                pos = '0;
            else
                pos = AXIS_BITS'((COORD_W+1)'(HALF) - ceil_v);
        end
        else
        begin
            if ({1'b0, hi} >= (COORD_W+1)'(DIVS - 1 - HALF))
                pos = AXIS_BITS'(DIVS - 1);
            else
                pos = AXIS_BITS'((COORD_W+1)'(HALF) + {1'b0, hi});
        end
        idx_next = CELL_BITS'(idx_reg * CELL_BITS'(DIVS)) + CELL_BITS'(pos);
    end

    // Hand-off to the queue.
    assign push                = (state_reg == F_PUSH);
    assign push_entry.req_type = req_reg;
    assign push_entry.in_grid  = inside_reg;
    assign push_entry.cell_idx = idx_reg;
    assign push_entry.weight   = weight_reg;

    // Sequencer: one axis at a time through offset, multiply and clamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg    <= in_req;
                        weight_reg <= in_weight;
                        pt_reg[0]  <= in_px;
                        pt_reg[1]  <= in_py;
                        pt_reg[2]  <= in_pz;
                        inside_reg <= in_box;
                        idx_reg    <= '0;
                        axis_reg   <= '0;
                        state_reg  <= in_box ? F_OFF : F_PUSH;
                    end
                end
                F_OFF:
                begin
                    neg_reg   <= neg_next;
                    mag_reg   <= mag_next;
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    prod_reg  <= mag_reg * cfg.cell_scale;
                    state_reg <= F_POS;
                end
                F_POS:
                begin
                    idx_reg <= idx_next;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= F_PUSH;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= F_OFF;
                    end
                end
                F_PUSH:
                begin
                    if (!full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule : vgwa_front

`default_nettype wire

### rtl/core/vgwa_queue.sv
// ---------------------------------------------------------------------------
// Voxel grid request queue
// Two-entry queue of classified requests between the front end and the
// cell store, so that each side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module vgwa_queue
    import vgwa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    output logic          full,
    input  wire logic     pop,
    output q_entry_t      pop_entry,
    output logic          empty
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule : vgwa_queue

`default_nettype wire

### rtl/core/vgwa_back.sv
// ---------------------------------------------------------------------------
// Voxel grid cell store
// Holds the cell sums, clears them after reset, and carries out the
// accumulate and read requests taken from the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module vgwa_back
    import vgwa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         empty,
    input  wire q_entry_t     pop_entry,
    output logic              pop,
    output logic              clearing,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              out_inside,
    output logic [INDEX_W-1:0] out_index,
    output logic [VALUE_W-1:0] out_value
);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ
    } bstate_t;

    logic [VALUE_W-1:0]   mem [CELL_COUNT];
    logic [VALUE_W-1:0]   rd_data_reg;

    bstate_t              state_reg;
    logic [CELL_BITS-1:0] clr_cnt_reg;
    q_entry_t             cur_reg;
    logic                 out_valid_reg;
    logic                 out_inside_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [VALUE_W-1:0]   out_value_reg;

    logic                 mem_we;
    logic [CELL_BITS-1:0] mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [VALUE_W:0]     sum;
    logic [VALUE_W-1:0]   sat_sum;

    assign clearing   = (state_reg == B_CLEAR);
    assign pop        = (state_reg == B_IDLE) && !empty && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_inside = out_inside_reg;
    assign out_index  = out_index_reg;
    assign out_value  = out_value_reg;

    // Saturating add of the weight to the cell just read.
    always_comb
    begin
        sum     = {1'b0, rd_data_reg} + (VALUE_W+1)'(cur_reg.weight);
        sat_sum = sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];
    end

    // Write port: the clearing sweep, or the write-back of an accumulate.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg.cell_idx;
        mem_wdata = sat_sum;
        if (state_reg == B_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == B_READ && cur_reg.req_type == REQ_ACCUM)
        begin
            mem_we = 1'b1;
        end
    end

    // Cell memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (pop)
            rd_data_reg <= mem[pop_entry.cell_idx];
    end

    // Request sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CELL_BITS'(1);
                    if (clr_cnt_reg == CELL_BITS'(CELL_COUNT - 1))
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg <= pop_entry;
                        if (pop_entry.in_grid)
                        begin
                            state_reg <= B_READ;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            out_inside_reg <= 1'b0;
                            out_index_reg  <= '0;
                            out_value_reg  <= '0;
                        end
                    end
                end
                B_READ:
                begin
                    out_valid_reg  <= 1'b1;
                    out_inside_reg <= 1'b1;
                    out_index_reg  <= INDEX_W'(cur_reg.cell_idx);
                    out_value_reg  <= (cur_reg.req_type == REQ_ACCUM) ? sat_sum : rd_data_reg;
                    state_reg      <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule : vgwa_back

`default_nettype wire

### rtl/core/voxel_grid_weight_accumulator.sv
// An inside point takes each of its three axes in turn through the shared offset, multiply
// and clamp datapath in the front end; an outside point skips it. The front end takes no new
// beat until the last one has been pushed into the queue.
// Reset: asynchronous, active low; afterwards the cell store clears itself, one cell
// per cycle, and s_tready stays low until that pass is done.
// ---------------------------------------------------------------------------
// Voxel grid weight accumulator
// Bins Q16.16 points into a cubic grid of cells and accumulates or reads
// a saturating weight sum per cell, behind a stream interface.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_grid_weight_accumulator
    import vgwa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_wdata,
    // Request stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [111:0]         s_tdata,  // point_x, point_y, point_z, weight
    input  wire logic [0:0]           s_tuser,  // req_type
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,  // cell_index, cell_value, zero pad
    output logic [0:0]                m_tuser   // inside_res
);

    cfg_t                cfg_reg;
    logic                clearing;
    logic                push;
    q_entry_t            push_entry;
    logic                full;
    logic                pop;
    q_entry_t            pop_entry;
    logic                empty;
    logic                out_inside;
    logic [INDEX_W-1:0]  out_index;
    logic [VALUE_W-1:0]  out_value;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x   <= '0;
            cfg_reg.centre_y   <= '0;
            cfg_reg.centre_z   <= '0;
            cfg_reg.extent_min <= -32'sd65536;
            cfg_reg.extent_max <= 32'sd65536;
            cfg_reg.cell_scale <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTRE_X:   cfg_reg.centre_x   <= $signed(cfg_wdata);
                CFG_CENTRE_Y:   cfg_reg.centre_y   <= $signed(cfg_wdata);
                CFG_CENTRE_Z:   cfg_reg.centre_z   <= $signed(cfg_wdata);
                CFG_EXTENT_MIN: cfg_reg.extent_min <= $signed(cfg_wdata);
                CFG_EXTENT_MAX: cfg_reg.extent_max <= $signed(cfg_wdata);
                CFG_CELL_SCALE: cfg_reg.cell_scale <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Front end: cube test and cell mapping.
    vgwa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .hold       (clearing),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (req_t'(s_tuser[0])),
        .in_px      (s_tdata[31:0]),
        .in_py      (s_tdata[63:32]),
        .in_pz      (s_tdata[95:64]),
        .in_weight  (s_tdata[111:96]),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Queue between front end and cell store.
    vgwa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    // Cell store and result register.
    vgwa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_entry  (pop_entry),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_inside (out_inside),
        .out_index  (out_index),
        .out_value  (out_value)
    );

    assign m_tdata = {1'b0, out_value, out_index};
    assign m_tuser = out_inside;

    // No request beat is taken while the cell store is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !s_tready)
        else $error("request beat taken during clearing pass");

    // A result for an outside point carries zero index and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 48'd0))
        else $error("outside result with nonzero fields");

    // The queue stays empty and no result is offered while the cell store is still clearing.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !m_tvalid && empty)
        else $error("activity in the back end during clearing pass");

endmodule : voxel_grid_weight_accumulator

`default_nettype wire

### test/vgwa_result_checker.sv
// ---------------------------------------------------------------------------
// Voxel grid result checker
// Watches the configuration port and both streams of the voxel grid weight
// accumulator, predicts the cell index and cell value of every request beat
// from its own copy of the registers and the cell sums, and compares each
// result beat with the oldest prediction.
// ---------------------------------------------------------------------------

module vgwa_result_checker
    import vgwa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [111:0]         s_tdata,   // point_x, point_y, point_z, weight
    input  logic [0:0]           s_tuser,   // req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,   // cell_index, cell_value, zero pad
    input  logic [0:0]           m_tuser,   // inside_res
    output int                   fail_count,
    output int                   outstanding
);

    typedef longint unsigned u64_t;

    // One predicted or observed result beat.
    typedef struct packed {
        logic               in_grid;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } bin_result_t;

    cfg_t               grid_cfg;
    logic [VALUE_W-1:0] grid_sums [CELL_COUNT];
    bin_result_t        pending_bins [$];

    // Maps one coordinate to its cell along an axis: the offset from the centre
    // times scale / 2^32, floored, shifted by half the grid and clamped.
    function automatic logic [AXIS_BITS-1:0] axis_slot(
        logic signed [COORD_W-1:0] p,
        logic signed [COORD_W-1:0] c,
        logic [COORD_W-1:0]        scale
    );
        longint offset;
        longint pos;
        u64_t   mag;
        u64_t   prod;
        u64_t   whole;
        offset = longint'(p) - longint'(c);
        mag    = (offset < 0) ? u64_t'(-offset) : u64_t'(offset);
        prod   = mag * u64_t'(scale);
        whole  = prod >> 32;
        if (offset < 0)
        begin
            // Floor of a negative product is minus the ceiling of its magnitude.
            if (prod[31:0] != 32'd0)
                whole = whole + 1;
            pos = longint'(HALF) - longint'(whole);
        end
        else
        begin
            pos = longint'(HALF) + longint'(whole);
        end
        if (pos < 0)
            pos = 0;
        if (pos > DIVS - 1)
            pos = DIVS - 1;
        return pos[AXIS_BITS-1:0];
    endfunction

    function automatic logic in_cube(logic signed [COORD_W-1:0] v);
        return (v >= grid_cfg.extent_min) && (v <= grid_cfg.extent_max);
    endfunction

    // Predicts the result of one request and applies it to the cell sums.
    function automatic bin_result_t bin_request(
        req_t                      kind,
        logic signed [COORD_W-1:0] px,
        logic signed [COORD_W-1:0] py,
        logic signed [COORD_W-1:0] pz,
        logic [WEIGHT_W-1:0]       w
    );
        bin_result_t      res;
        logic [31:0]      flat;
        logic [VALUE_W:0] sum;
        res = '0;
        if (!(in_cube(px) && in_cube(py) && in_cube(pz)))
            return res;
        flat = (32'(axis_slot(px, grid_cfg.centre_x, grid_cfg.cell_scale)) * DIVS
                + 32'(axis_slot(py, grid_cfg.centre_y, grid_cfg.cell_scale))) * DIVS
                + 32'(axis_slot(pz, grid_cfg.centre_z, grid_cfg.cell_scale));
        if (kind == REQ_ACCUM)
        begin
            // The running sum saturates at all ones.
            sum = {1'b0, grid_sums[flat]} + {17'd0, w};
            grid_sums[flat] = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
        end
        res.in_grid = 1'b1;
        res.index   = flat[INDEX_W-1:0];
        res.value   = grid_sums[flat];
        return res;
    endfunction

    // Predict on every request beat, compare on every result beat.
    always @(posedge clk or negedge rst_n)
    begin
        bin_result_t want;
        bin_result_t got;
        if (!rst_n)
        begin
            grid_cfg.centre_x   = '0;
            grid_cfg.centre_y   = '0;
            grid_cfg.centre_z   = '0;
            grid_cfg.extent_min = -32'sd65536;
            grid_cfg.extent_max = 32'sd65536;
            grid_cfg.cell_scale = 32'd1048576;
            foreach (grid_sums[i])
                grid_sums[i] = '0;
            pending_bins.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // Result beats come first: a request taken at this edge is younger.
            if (m_tvalid && m_tready)
            begin
                got.in_grid = m_tuser[0];
                got.index   = m_tdata[INDEX_W-1:0];
                got.value   = m_tdata[INDEX_W +: VALUE_W];
                if (pending_bins.size() == 0)
                begin
                    if (fail_count < 10)
                        $display({"result beat with no request pending: ",
                                  "inside=%0d index=%0d value=%h"},
                                 got.in_grid, got.index, got.value);
                    fail_count++;
                end
                else
                begin
                    want = pending_bins.pop_front();
                    if (got.in_grid !== want.in_grid || got.index !== want.index ||
                        got.value !== want.value)
                    begin
                        if (fail_count < 10)
                            $display({"result mismatch: expected inside=%0d index=%0d ",
                                      "value=%h, got inside=%0d index=%0d value=%h"},
                                     want.in_grid, want.index, want.value,
                                     got.in_grid, got.index, got.value);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                want = bin_request(req_t'(s_tuser[0]), s_tdata[31:0],
                                   s_tdata[63:32], s_tdata[95:64],
                                   s_tdata[111:96]);
                pending_bins = {pending_bins, want};
            end

            // Register writes; unused indexes change nothing.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTRE_X:   grid_cfg.centre_x   = cfg_wdata;
                    CFG_CENTRE_Y:   grid_cfg.centre_y   = cfg_wdata;
                    CFG_CENTRE_Z:   grid_cfg.centre_z   = cfg_wdata;
                    CFG_EXTENT_MIN: grid_cfg.extent_min = cfg_wdata;
                    CFG_EXTENT_MAX: grid_cfg.extent_max = cfg_wdata;
                    CFG_CELL_SCALE: grid_cfg.cell_scale = cfg_wdata;
                    default: ;
                endcase
            end

            outstanding = pending_bins.size();
        end
    end

endmodule

### test/tb_voxel_grid_weight_accumulator.sv
// ---------------------------------------------------------------------------
// Voxel grid weight accumulator testbench
// Drives directed and random point beats through several grid settings,
// with bursty input, a stalling output and one long output hold-off, and
// ends with a gapless run of full weights into one cell. A separate checker
// predicts and compares every result beat.
// ---------------------------------------------------------------------------

module tb_voxel_grid_weight_accumulator;
    import vgwa_pkg::*;

    localparam int LIMIT_CYCLES    = 4_000_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_BEATS     = 52;
    localparam int SOAK_BEATS      = 30;
    localparam int TAIL_CYCLES     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef longint unsigned u64_pick_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [111:0]         s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tready  = 1'b1;
    wire logic            s_tready;
    wire logic            m_tvalid;
    wire logic [47:0]     m_tdata;
    wire logic [0:0]      m_tuser;

    int                   fail_count;
    int                   outstanding;
    int unsigned          cycle_count = 0;

    // Sender state.
    int                   burst_left = 0;
    bit                   no_gaps    = 1'b0;
    bit                   hold_go    = 1'b0;
    logic signed [31:0]   span_lo    = -32'sd65536;
    logic signed [31:0]   span_hi    = 32'sd65536;
    logic [COORD_W-1:0]   hot_pts [8][3];
    logic [COORD_W-1:0]   last_pt [3];

    voxel_grid_weight_accumulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    vgwa_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock with a period of four.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[voxel_grid_weight_accumulator] ERROR");
            $finish;
        end
    end

    // Output side: stall modes, each held for a random span, plus one
    // long hold-off once the first random phase starts.
    initial
    begin
        int mode;
        int mode_left;
        int rx_cycle;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        rx_cycle  = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((rx_cycle % 7) < 3);
                endcase
            end
        end
    end

    // One register write; the write enable is low again before the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_grid(
        logic [COORD_W-1:0] cx,
        logic [COORD_W-1:0] cy,
        logic [COORD_W-1:0] cz,
        logic [COORD_W-1:0] lo,
        logic [COORD_W-1:0] hi,
        logic [COORD_W-1:0] scale
    );
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_CENTRE_Z, cz);
        write_reg(CFG_EXTENT_MIN, lo);
        write_reg(CFG_EXTENT_MAX, hi);
        write_reg(CFG_CELL_SCALE, scale);
        span_lo = lo;
        span_hi = hi;
    endtask

    // Offers one request beat and returns at the falling edge after it is taken.
    // Between bursts the valid line may drop for a random gap.
    task automatic offer_point(
        req_t                kind,
        logic [COORD_W-1:0]  px,
        logic [COORD_W-1:0]  py,
        logic [COORD_W-1:0]  pz,
        logic [WEIGHT_W-1:0] w
    );
        int gap;
        if (burst_left == 0 && !no_gaps)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tuser  <= kind;
        s_tdata  <= {w, pz, py, px};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic close_burst();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Mostly inside the cube, sometimes on or just past a bound, sometimes anywhere.
    function automatic logic [COORD_W-1:0] pick_coord();
        longint span;
        u64_pick_t r;
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0 || span_lo > span_hi)
            return $urandom;
        if (sel == 1)
            return span_lo;
        if (sel == 2)
            return span_hi;
        if (sel == 3)
            return span_lo - 1;
        if (sel == 4)
            return span_hi + 1;
        span = longint'(span_hi) - longint'(span_lo) + 1;
        r    = {$urandom, $urandom};
        return 32'(longint'(span_lo) + longint'(r % u64_pick_t'(span)));
    endfunction

    // Random beat: repeats of the last point and a small pool of hot points give
    // back-to-back hits on one cell; the rest are fresh points.
    task automatic random_beat();
        logic [COORD_W-1:0]  pt [3];
        logic [WEIGHT_W-1:0] w;
        req_t                kind;
        int                  route;
        int                  slot;
        route = $urandom_range(0, 9);
        slot  = $urandom_range(0, 7);
        for (int a = 0; a < 3; a++)
        begin
            if (route < 2)
                pt[a] = last_pt[a];
            else if (route < 6)
                pt[a] = hot_pts[slot][a];
            else
                pt[a] = pick_coord();
        end
        kind = ($urandom_range(0, 3) == 0) ? REQ_READ : REQ_ACCUM;
        case ($urandom_range(0, 7))
            0: w = '0;
            1: w = '1;
            default: w = WEIGHT_W'($urandom);
        endcase
        last_pt = pt;
        offer_point(kind, pt[0], pt[1], pt[2], w);
    endtask

    task automatic run_random(int beats);
        foreach (hot_pts[i, a])
            hot_pts[i][a] = pick_coord();
        for (int a = 0; a < 3; a++)
            last_pt[a] = hot_pts[0][a];
        repeat (beats) random_beat();
        close_burst();
        wait_drained();
    endtask

    // A grid of random size and place, its scale matched to its width most of the time.
    task automatic random_grid();
        longint half;
        longint mid;
        longint lo;
        longint hi;
        longint sc;
        int     e;
        e    = $urandom_range(4, 30);
        half = (longint'(1) << e) + longint'($urandom_range(0, (1 << e) - 1));
        mid  = longint'($signed($urandom)) >>> $urandom_range(0, 8);
        lo   = mid - half;
        hi   = mid + half;
        if (lo < -(longint'(1) << 31))
            lo = -(longint'(1) << 31);
        if (hi > (longint'(1) << 31) - 1)
            hi = (longint'(1) << 31) - 1;
        sc = (longint'(DIVS) << 32) / (hi - lo + 1);
        if (sc > longint'(32'hFFFF_FFFF))
            sc = longint'(32'hFFFF_FFFF);
        if ($urandom_range(0, 3) == 0)
            sc = longint'($urandom);
        set_grid(32'(mid + longint'($urandom_range(0, 255)) - 128),
                 32'(mid + longint'($urandom_range(0, 255)) - 128),
                 32'(mid + longint'($urandom_range(0, 255)) - 128),
                 32'(lo), 32'(hi), 32'(sc));
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // The cell store clears itself before the first beat is taken.
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);

        // Reset grid: centre, corners, bounds, just outside, fractional offsets.
        offer_point(REQ_ACCUM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        offer_point(REQ_READ,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h1234);
        offer_point(REQ_ACCUM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001);
        offer_point(REQ_ACCUM, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 16'h0000);
        offer_point(REQ_ACCUM, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h8000);
        offer_point(REQ_READ,  32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        offer_point(REQ_ACCUM, 32'hFFFE_FFFF, 32'h0000_0000, 32'h0000_0000, 16'h00FF);
        offer_point(REQ_ACCUM, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 16'h5555);
        offer_point(REQ_ACCUM, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 16'hAAAA);
        offer_point(REQ_READ,  32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 16'h0000);
        offer_point(REQ_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0100);
        offer_point(REQ_ACCUM, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 16'h0200);
        offer_point(REQ_ACCUM, 32'h0000_0FFF, 32'hFFFF_F000, 32'h0000_1000, 16'h7FFF);
        offer_point(REQ_READ,  32'h0000_0FFF, 32'hFFFF_F000, 32'h0000_1000, 16'h0000);
        offer_point(REQ_ACCUM, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 16'hFFFF);
        offer_point(REQ_ACCUM, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 16'hFFFF);
        close_burst();
        wait_drained();

        // Writes to unused indexes must leave the grid as it was.
        write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_7, 32'h1234_5678);
        offer_point(REQ_READ, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        close_burst();
        wait_drained();

        // First random phase on the reset grid, with the long output hold-off.
        hold_go = 1'b1;
        run_random(40);

        // Widest cube, extreme centres and the largest scale.
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer_point(REQ_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'hFFFF);
        offer_point(REQ_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001);
        offer_point(REQ_READ,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000);
        offer_point(REQ_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h00FF);
        close_burst();
        wait_drained();
        run_random(40);

        // Zero scale: every inside point lands in the middle cell.
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'hFFF0_0000, 32'h0010_0000, 32'h0000_0000);
        run_random(20);

        // Inverted extent: every point is outside.
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0010_0000);
        offer_point(REQ_ACCUM, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        offer_point(REQ_READ,  32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 16'h0000);
        close_burst();
        wait_drained();
        run_random(20);

        // Degenerate cube of one point.
        set_grid(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                 32'h0005_0000, 32'h0005_0000, 32'h0010_0000);
        offer_point(REQ_ACCUM, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 16'h4321);
        close_burst();
        wait_drained();
        run_random(10);

        repeat (RANDOM_PHASES)
        begin
            random_grid();
            run_random(PHASE_BEATS);
        end

        // Gapless run of full weights into one cell, then a read of it.
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 32'hFFFF_0000, 32'h0001_0000, 32'h0010_0000);
        no_gaps = 1'b1;
        repeat (SOAK_BEATS)
            offer_point(REQ_ACCUM, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'hFFFF);
        offer_point(REQ_READ, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h0000);
        no_gaps = 1'b0;
        close_burst();
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[voxel_grid_weight_accumulator] OK");
        else
            $display("[voxel_grid_weight_accumulator] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/vgwa_pkg.sv
rtl/core/vgwa_front.sv
rtl/core/vgwa_queue.sv
rtl/core/vgwa_back.sv
rtl/core/voxel_grid_weight_accumulator.sv
test/vgwa_result_checker.sv
test/tb_voxel_grid_weight_accumulator.sv
